/* design/twg_pkg.sv */
// shared types, constants and helpers of the tone waveform generator
package twg_pkg;

   localparam int AMP_W   = 12;
   localparam int FREQ_W  = 15;
   localparam int DELTA_W = 16;
   localparam int LEVEL_W = 16;
   localparam int MULT_W  = 16;

   localparam logic [LEVEL_W-1:0] DURATION_TICKS = 16'd44164;
   localparam logic [15:0]        SQUARE_RATE    = 16'd41000;
   localparam logic [FREQ_W-1:0]  MAX_FREQUENCY  = 15'd20000;

   localparam logic [AMP_W-1:0]  AMP_MAX    = 12'd4095;
   localparam logic [AMP_W-1:0]  AMP_RESET  = 12'd200;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd500;
   localparam logic [FREQ_W-1:0] FREQ_MIN   = 15'd1;

   // q0.32 step scale
   localparam logic [16:0] STEP_K = 17'd97251;

   localparam int MUL_HI_W  = 18;
   localparam int MUL_LO_W  = 28;
   localparam int MUL_CNT_W = 5;
   localparam logic [MUL_CNT_W-1:0] MUL_FIRST_LAST  = 5'd15;
   localparam logic [MUL_CNT_W-1:0] MUL_SECOND_LAST = 5'd27;

   localparam int DIV_NUM_W = 18;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd17;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_START     = 2'd1,
      OP_VOLUME    = 2'd2,
      OP_FREQUENCY = 2'd3
   } twg_op_type;

   typedef enum logic [1:0] {
      WF_IDLE     = 2'd0,
      WF_TRIANGLE = 2'd1,
      WF_SAW      = 2'd2,
      WF_SQUARE   = 2'd3
   } twg_wave_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } twg_state_type;

   function automatic logic [AMP_W-1:0] sat12(input logic [LEVEL_W-1:0] v);
      sat12 = (v > {4'b0, AMP_MAX}) ? AMP_MAX : v[AMP_W-1:0];
   endfunction

endpackage

/* design/twg_if.sv */
// request and response channel interfaces
interface twg_req_if import twg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic [1:0]                waveform;
   logic signed [DELTA_W-1:0] delta;

   modport source (output valid, operation, waveform, delta, input ready);
   modport sink (input valid, operation, waveform, delta, output ready);
endinterface

interface twg_rsp_if import twg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [AMP_W-1:0] sample;
   logic             active;

   modport source (output valid, sample, active, input ready);
   modport sink (input valid, sample, active, output ready);
endinterface

/* design/twg_mul.sv */
// bit-serial step multiplier: round(amp * mult * k) in q0.32
module twg_mul import twg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [AMP_W-1:0]   amp,
   input  logic [MULT_W-1:0]  mult,
   output logic               done,
   output logic [LEVEL_W-1:0] step
);

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_HI_W-1:0]  hi_ff, hi_in;
   logic [MUL_LO_W-1:0]  lo_ff, lo_in;
   logic [16:0]          mcand;
   logic [MUL_HI_W-1:0]  sum;

   assign mcand = phase_ff ? STEP_K : {5'b0, amp};
   assign sum   = hi_ff + (lo_ff[0] ? {1'b0, mcand} : '0);

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = MUL_FIRST_LAST;
         hi_in    = '0;
         lo_in    = {12'b0, mult};
      end else if (busy_ff) begin
         if (!phase_ff && cnt_ff == '0) begin
            // amp * mult done, it becomes the multiplier of k
            phase_in = 1'b1;
            cnt_in   = MUL_SECOND_LAST;
            hi_in    = '0;
            lo_in    = {sum[12:0], lo_ff[MUL_LO_W-1:13]};
         end else begin
            hi_in  = {1'b0, sum[MUL_HI_W-1:1]};
            lo_in  = {sum[0], lo_ff[MUL_LO_W-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done = !busy_ff;
   // round half up at bit 31 of the 45-bit product
   assign step = {3'b0, hi_ff[16:4]} + {15'b0, hi_ff[3]};

endmodule

/* design/twg_div.sv */
// bit-serial restoring divider for the square half period
module twg_div import twg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FREQ_W-1:0]  freq,
   output logic               done,
   output logic [LEVEL_W-1:0] period
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]          rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [15:0]          divisor;
   logic [16:0]          shifted;
   logic                 fits;

   assign divisor = {freq, 1'b0};
   assign shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_LAST;
         rem_in  = '0;
         // 2 * rate + f, so the quotient rounds half up
         quo_in  = {1'b0, SQUARE_RATE, 1'b0} + {3'b0, freq};
      end else if (busy_ff) begin
         rem_in = fits ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done   = !busy_ff;
   assign period = quo_ff[LEVEL_W-1:0];

endmodule

/* design/tone_waveform_generator.sv */
// tone waveform generator top level: event decode, waveform state and output register
//
// req_if carries one item per handshake: a sample tick or a control event
// (start waveform, change volume, change frequency). Control events take
// effect in the cycle they are accepted and give no response item.
// Each tick gives one rsp_if item: the 12-bit DAC sample and the active flag.
// A tick in a playing mode runs the bit-serial step multiplier (amp * f,
// or amp * 2f for the triangle, then times the q0.32 scale) and in parallel
// the bit-serial period divider; the response is registered once both are
// done and the output register is free, and req_if.ready comes back with
// it, so no item is taken meanwhile. The slower multiplier sets the pace.
// A tick while idle does not wait for the arithmetic units.
// Control events are taken every cycle while no tick is in progress.
// The response sits in an output register: a new item is accepted while
// it waits, and a further tick holds in its last state until rsp_if.ready.
// Reset (synchronous, active high) returns to idle mode with volume 200,
// frequency 500 and all waveform levels and counters cleared.
module tone_waveform_generator import twg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   twg_req_if.sink   req_if,
   twg_rsp_if.source rsp_if
);

   twg_state_type      state_ff, state_in;
   twg_wave_type       mode_ff, mode_in;
   logic [LEVEL_W-1:0] elapsed_ff, elapsed_in;
   logic [AMP_W-1:0]   amp_ff, amp_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [LEVEL_W-1:0] tri_ff, tri_in;
   logic               tri_rising_ff, tri_rising_in;
   logic [LEVEL_W-1:0] saw_ff, saw_in;
   logic               sq_high_ff, sq_high_in;
   logic [LEVEL_W-1:0] sq_cnt_ff, sq_cnt_in;
   logic [AMP_W-1:0]   held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AMP_W-1:0]   rsp_sample_ff, rsp_sample_in;
   logic               rsp_active_ff, rsp_active_in;

   twg_op_type         op;
   logic               accept;
   logic               unit_start;
   logic               out_free;
   logic               mul_done, div_done;
   logic [MULT_W-1:0]  mult;
   logic [LEVEL_W-1:0] step, period;

   logic signed [17:0] vol_sum, freq_sum;
   logic [AMP_W-1:0]   vol_clamp;
   logic [FREQ_W-1:0]  freq_clamp;

   logic               tri_rise;
   logic [LEVEL_W-1:0] tri_next, saw_base, saw_next, sq_cnt_next;
   logic               tri_rising_next, sq_expired, sq_high_next;
   logic [AMP_W-1:0]   wave_sample;

   assign op       = twg_op_type'(req_if.operation);
   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign mult     = (mode_ff == WF_TRIANGLE) ? {freq_ff, 1'b0} : {1'b0, freq_ff};

   twg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .amp   (amp_ff),
      .mult  (mult),
      .done  (mul_done),
      .step  (step)
   );

   twg_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start),
      .freq   (freq_ff),
      .done   (div_done),
      .period (period)
   );

   // volume and frequency clamps
   assign vol_sum  = $signed({6'b0, amp_ff}) + $signed({{2{req_if.delta[15]}}, req_if.delta});
   assign freq_sum = $signed({3'b0, freq_ff}) + $signed({{2{req_if.delta[15]}}, req_if.delta});

   always_comb begin
      if (vol_sum < 0) begin
         vol_clamp = '0;
      end else if (vol_sum > $signed({6'b0, AMP_MAX})) begin
         vol_clamp = AMP_MAX;
      end else begin
         vol_clamp = vol_sum[AMP_W-1:0];
      end
      if (freq_sum < $signed({3'b0, FREQ_MIN})) begin
         freq_clamp = FREQ_MIN;
      end else if (freq_sum > $signed({3'b0, MAX_FREQUENCY})) begin
         freq_clamp = MAX_FREQUENCY;
      end else begin
         freq_clamp = freq_sum[FREQ_W-1:0];
      end
   end

   // next waveform levels for the current tick
   always_comb begin
      tri_rise        = tri_rising_ff && !(tri_ff > {4'b0, amp_ff});
      tri_next        = tri_ff;
      tri_rising_next = tri_rise;
      if (tri_rise) begin
         tri_next = tri_ff + step;
      end else if (tri_ff < step) begin
         tri_rising_next = 1'b1;
      end else begin
         tri_next = tri_ff - step;
      end
      saw_base     = (saw_ff > {4'b0, amp_ff}) ? '0 : saw_ff;
      saw_next     = saw_base + step;
      sq_expired   = sq_cnt_ff >= period;
      sq_high_next = sq_expired ? !sq_high_ff : sq_high_ff;
      sq_cnt_next  = sq_expired ? '0 : sq_cnt_ff + 1'b1;
      case (mode_ff)
         WF_TRIANGLE: wave_sample = sat12(tri_next);
         WF_SAW:      wave_sample = sat12(saw_next);
         WF_SQUARE: begin
            if (sq_expired) begin
               wave_sample = sq_high_next ? amp_ff : '0;
            end else begin
               wave_sample = held_ff;
            end
         end
         default:     wave_sample = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      elapsed_in    = elapsed_ff;
      amp_in        = amp_ff;
      freq_in       = freq_ff;
      tri_in        = tri_ff;
      tri_rising_in = tri_rising_ff;
      saw_in        = saw_ff;
      sq_high_in    = sq_high_ff;
      sq_cnt_in     = sq_cnt_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      unit_start    = 1'b0;
      req_if.ready  = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               unique case (op)
                  OP_TICK: begin
                     unit_start = 1'b1;
                     state_in   = ST_CALC;
                  end
                  OP_START: begin
                     mode_in    = twg_wave_type'(req_if.waveform);
                     elapsed_in = '0;
                  end
                  OP_VOLUME:    amp_in  = vol_clamp;
                  OP_FREQUENCY: freq_in = freq_clamp;
               endcase
            end
         end
         ST_CALC: begin
            if (mode_ff == WF_IDLE || (mul_done && div_done)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (mode_ff == WF_IDLE) begin
                  elapsed_in    = '0;
                  held_in       = '0;
                  rsp_sample_in = '0;
                  rsp_active_in = 1'b0;
               end else begin
                  if (elapsed_ff >= DURATION_TICKS) begin
                     elapsed_in = '0;
                     mode_in    = WF_IDLE;
                  end else begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
                  case (mode_ff)
                     WF_TRIANGLE: begin
                        tri_in        = tri_next;
                        tri_rising_in = tri_rising_next;
                     end
                     WF_SAW: saw_in = saw_next;
                     default: begin
                        sq_high_in = sq_high_next;
                        sq_cnt_in  = sq_cnt_next;
                     end
                  endcase
                  held_in       = wave_sample;
                  rsp_sample_in = wave_sample;
                  rsp_active_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= WF_IDLE;
         elapsed_ff    <= '0;
         amp_ff        <= AMP_RESET;
         freq_ff       <= FREQ_RESET;
         tri_ff        <= '0;
         tri_rising_ff <= 1'b1;
         saw_ff        <= '0;
         sq_high_ff    <= 1'b0;
         sq_cnt_ff     <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         elapsed_ff    <= elapsed_in;
         amp_ff        <= amp_in;
         freq_ff       <= freq_in;
         tri_ff        <= tri_in;
         tri_rising_ff <= tri_rising_in;
         saw_ff        <= saw_in;
         sq_high_ff    <= sq_high_in;
         sq_cnt_ff     <= sq_cnt_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;
   assign rsp_if.active = rsp_active_ff;

   // frequency stays inside its clamp range
   assert property (@(posedge clock) disable iff (reset)
      freq_ff >= FREQ_MIN && freq_ff <= MAX_FREQUENCY)
      else $error("frequency out of range");

   // a taken tick blocks further items until its response is built
   assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_TICK |=> !req_if.ready)
      else $error("item taken while a tick is in progress");

   // an idle response carries a zero sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_active_ff |-> rsp_sample_ff == '0)
      else $error("idle response with nonzero sample");

   // a finished tick waits while the output register is still full
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && rsp_valid_ff && !rsp_if.ready |=> state_ff == ST_EMIT)
      else $error("response overwritten before it was taken");

endmodule

/* test/tb_tone_waveform_generator.sv */
`timescale 1ns / 1ps
// self-checking testbench of the tone waveform generator: directed cases and random traffic
module tb_tone_waveform_generator;
   import twg_pkg::*;

   typedef struct packed {
      logic [AMP_W-1:0] sample;
      logic             active;
   } dac_item_type;

   logic clock;
   logic reset;

   twg_req_if req_ch ();
   twg_rsp_if rsp_ch ();

   tone_waveform_generator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predicted generator state
   twg_wave_type       tone_mode;
   logic [15:0]        play_ticks;
   logic [AMP_W-1:0]   volume_level;
   logic [FREQ_W-1:0]  pitch;
   logic [LEVEL_W-1:0] tri_level;
   logic               tri_rising;
   logic [LEVEL_W-1:0] saw_level;
   logic               sq_high;
   logic [15:0]        sq_count;
   logic [AMP_W-1:0]   last_sample;

   dac_item_type expected_samples[$];

   int fail_count;
   int items_sent;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      #(200_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic reset_tone_model();
      tone_mode    = WF_IDLE;
      play_ticks   = '0;
      volume_level = AMP_RESET;
      pitch        = FREQ_RESET;
      tri_level    = '0;
      tri_rising   = 1'b1;
      saw_level    = '0;
      sq_high      = 1'b0;
      sq_count     = '0;
      last_sample  = '0;
   endtask

   // amplitude times frequency times the q0.32 scale, rounded
   function automatic logic [31:0] level_step(input logic [AMP_W-1:0] amp,
                                              input logic [16:0] freq);
      logic [63:0] prod;
      prod = 64'(amp) * 64'(freq) * 64'(STEP_K);
      return 32'((prod + 64'h8000_0000) >> 32);
   endfunction

   function automatic logic [AMP_W-1:0] dac_clip(input logic [LEVEL_W-1:0] level);
      if (level > LEVEL_W'(AMP_MAX)) begin
         return AMP_MAX;
      end
      return level[AMP_W-1:0];
   endfunction

   task automatic predict_tone(input twg_op_type op, input twg_wave_type wf,
                               input logic signed [DELTA_W-1:0] delta);
      int               v;
      twg_wave_type     cur;
      logic [31:0]      st;
      logic [31:0]      period;
      logic [AMP_W-1:0] s;
      case (op)
         OP_START: begin
            tone_mode  = wf;
            play_ticks = '0;
         end
         OP_VOLUME: begin
            v = int'(volume_level) + int'(delta);
            if (v < 0) v = 0;
            if (v > int'(AMP_MAX)) v = int'(AMP_MAX);
            volume_level = v[AMP_W-1:0];
         end
         OP_FREQUENCY: begin
            v = int'(pitch) + int'(delta);
            if (v < int'(FREQ_MIN)) v = int'(FREQ_MIN);
            if (v > int'(MAX_FREQUENCY)) v = int'(MAX_FREQUENCY);
            pitch = v[FREQ_W-1:0];
         end
         default: begin
            if (tone_mode == WF_IDLE) begin
               play_ticks  = '0;
               last_sample = '0;
               expected_samples.push_back('{sample: '0, active: 1'b0});
            end else begin
               cur = tone_mode;
               if (play_ticks >= DURATION_TICKS) begin
                  play_ticks = '0;
                  tone_mode  = WF_IDLE;
               end else begin
                  play_ticks = play_ticks + 16'd1;
               end
               case (cur)
                  WF_TRIANGLE: begin
                     st = level_step(volume_level, {1'b0, pitch, 1'b0});
                     if (tri_level > LEVEL_W'(volume_level)) tri_rising = 1'b0;
                     if (tri_rising) begin
                        tri_level = tri_level + st[15:0];
                     end else if (32'(tri_level) < st) begin
                        tri_rising = 1'b1;
                     end else begin
                        tri_level = tri_level - st[15:0];
                     end
                     s = dac_clip(tri_level);
                  end
                  WF_SAW: begin
                     if (saw_level > LEVEL_W'(volume_level)) saw_level = '0;
                     st = level_step(volume_level, {2'b0, pitch});
                     saw_level = saw_level + st[15:0];
                     s = dac_clip(saw_level);
                  end
                  default: begin
                     period = (2 * 32'(SQUARE_RATE) + 32'(pitch)) / (2 * 32'(pitch));
                     if (32'(sq_count) >= period) begin
                        sq_count = '0;
                        sq_high  = ~sq_high;
                        s = sq_high ? volume_level : '0;
                     end else begin
                        sq_count = sq_count + 16'd1;
                        s = last_sample;
                     end
                  end
               endcase
               last_sample = s;
               expected_samples.push_back('{sample: s, active: 1'b1});
            end
         end
      endcase
   endtask

   task automatic send_item(input twg_op_type op, input twg_wave_type wf,
                            input logic signed [DELTA_W-1:0] delta);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.waveform  <= wf;
      req_ch.delta     <= delta;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_tone(op, wf, delta);
      items_sent++;
   endtask

   function automatic twg_wave_type any_wave();
      return twg_wave_type'($urandom_range(3));
   endfunction

   function automatic logic signed [DELTA_W-1:0] any_delta();
      return DELTA_W'($urandom);
   endfunction

   // mostly small steps, sometimes the full signed range
   function automatic logic signed [DELTA_W-1:0] pick_delta(input int span);
      if ($urandom_range(99) < 85) begin
         return DELTA_W'(int'($urandom_range(2 * span)) - span);
      end
      return any_delta();
   endfunction

   task automatic send_ticks(input int count);
      repeat (count) send_item(OP_TICK, any_wave(), any_delta());
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      dac_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected item, sample", int'(rsp_ch.sample), 0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_ch.sample !== want.sample) begin
               report_mismatch("sample", int'(rsp_ch.sample), int'(want.sample));
            end
            if (rsp_ch.active !== want.active) begin
               report_mismatch("active", int'(rsp_ch.active), int'(want.active));
            end
         end
      end
   end

   task automatic test_idle_ticks();
      send_ticks(2);
   endtask

   task automatic test_waveform_starts();
      send_item(OP_START, WF_TRIANGLE, any_delta());
      send_ticks(3);
      send_item(OP_START, WF_SAW, any_delta());
      send_ticks(3);
      send_item(OP_START, WF_SQUARE, any_delta());
      send_ticks(3);
   endtask

   // clamps at both ends, square hold and counter past a shortened period
   task automatic test_clamps_and_hold();
      send_item(OP_VOLUME, any_wave(), 16'sh7FFF);
      send_item(OP_FREQUENCY, any_wave(), 16'sh8000);
      send_ticks(3);
      send_item(OP_FREQUENCY, any_wave(), 16'sh7FFF);
      send_ticks(2);
      send_item(OP_VOLUME, any_wave(), 16'sh8000);
      send_ticks(1);
      send_item(OP_START, WF_IDLE, any_delta());
      send_ticks(1);
   endtask

   task automatic send_random_sequence();
      twg_wave_type wf;
      if ($urandom_range(99) < 20) begin
         send_item(twg_op_type'($urandom_range(3)), any_wave(), any_delta());
      end else begin
         if ($urandom_range(2) == 0) send_item(OP_VOLUME, any_wave(), pick_delta(600));
         if ($urandom_range(2) == 0) send_item(OP_FREQUENCY, any_wave(), pick_delta(3000));
         wf = ($urandom_range(9) == 0) ? WF_IDLE : twg_wave_type'($urandom_range(1, 3));
         send_item(OP_START, wf, any_delta());
         send_ticks($urandom_range(1, 12));
      end
   endtask

   task automatic test_random_traffic();
      int first;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         first = items_sent;
         while (items_sent - first < 262) send_random_sequence();
      end
   endtask

   initial begin
      int guard;
      fail_count       = 0;
      items_sent       = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.waveform  = '0;
      req_ch.delta     = '0;
      rsp_ch.ready     = 1'b0;
      reset_tone_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_waveform_starts();
      test_clamps_and_hold();
      test_random_traffic();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      guard = 0;
      while (expected_samples.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_samples.size() != 0) begin
         report_mismatch("items never delivered", 0, expected_samples.size());
      end
      repeat (60) @(posedge clock);

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
